// ===== hw/rtl/artq_pkg.sv =====
// Shared types, codes and sizes for the ack/retry transmit queue.
// No dependencies; the datapath, controller and core refer to this package by scoped names.
package artq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int TIMER_W = 20;
	localparam int ATT_W   = 4;

	// input commands
	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_ACK  = 2'd1;
	localparam logic [1:0] CMD_POLL = 2'd2;
	localparam logic [1:0] CMD_TICK = 2'd3;

	// result status codes
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_FULL      = 3'd1;
	localparam logic [2:0] STS_ACK_DUP   = 3'd2;
	localparam logic [2:0] STS_ACK_UNK   = 3'd3;
	localparam logic [2:0] STS_EMPTY     = 3'd4;
	localparam logic [2:0] STS_WAITING   = 3'd5;
	localparam logic [2:0] STS_EXHAUSTED = 3'd6;
	localparam logic [2:0] STS_TICK      = 3'd7;

	// configuration register indexes
	localparam logic [1:0] REG_BASE_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_LONG_FACTOR  = 2'd1;
	localparam logic [1:0] REG_PAIRING_CODE = 2'd2;
	localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] RST_BASE_TIMEOUT = 16'd100;
	localparam logic [3:0]  RST_LONG_FACTOR  = 4'd5;
	localparam logic [7:0]  RST_PAIRING_CODE = 8'd0;
	localparam logic [2:0]  RST_MAX_ATTEMPTS = 3'd3;

	// controller to datapath commands
	typedef struct packed {
		logic load;  // capture the accepted input item
		logic exec;  // perform the item and load the result register
	} ctl_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/artq_req_if.sv =====
// Input item channel: valid/ready handshake with the queue command payload.
// Depends on nothing.
interface artq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  seq;
	logic [7:0]  command_byte;
	logic [15:0] packet_handle;

	modport source (output valid, cmd, seq, command_byte, packet_handle, input ready);
	modport sink   (input valid, cmd, seq, command_byte, packet_handle, output ready);
endinterface

// ===== hw/rtl/artq_rsp_if.sv =====
// Result channel: valid/ready handshake with the queue result payload.
// Depends on nothing.
interface artq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        transmit;
	logic [7:0]  out_seq;
	logic [15:0] out_handle;
	logic [3:0]  attempt_count;
	logic        link_lost;

	modport source (output valid, status, transmit, out_seq, out_handle, attempt_count,
		link_lost, input ready);
	modport sink   (input valid, status, transmit, out_seq, out_handle, attempt_count,
		link_lost, output ready);
endinterface

// ===== hw/rtl/artq_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and write data.
// Depends on nothing.
interface artq_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  idx;
	logic [15:0] data;

	modport source (output valid, idx, data, input ready);
	modport sink   (input valid, idx, data, output ready);
endinterface

// ===== hw/rtl/artq_datapath.sv =====
// Datapath: item capture, slot store, ring indexes, retry timer, config and result registers.
// Depends on artq_pkg; driven by artq_ctrl through artq_pkg::ctl_t.
module artq_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  artq_pkg::ctl_t       ctl,
	input  logic [1:0]           cmd,
	input  logic [7:0]           seq,
	input  logic [7:0]           command_byte,
	input  logic [15:0]          packet_handle,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [15:0]          cfg_data,
	output logic [2:0]           status,
	output logic                 transmit,
	output logic [7:0]           out_seq,
	output logic [15:0]          out_handle,
	output logic [3:0]           attempt_count,
	output logic                 link_lost
);

	logic [1:0]  cmd_q;
	logic [7:0]  seq_q;
	logic [7:0]  cbyte_q;
	logic [15:0] handle_q;

	logic [7:0]  slot_seq_q    [artq_pkg::DEPTH];
	logic [7:0]  slot_cmd_q    [artq_pkg::DEPTH];
	logic [15:0] slot_handle_q [artq_pkg::DEPTH];

	logic [artq_pkg::IDX_W-1:0]   head_q, tail_q;
	logic [artq_pkg::ATT_W-1:0]   attempts_q;
	logic [artq_pkg::TIMER_W-1:0] timer_q;

	logic [15:0] base_q;
	logic [3:0]  factor_q;
	logic [7:0]  pair_q;
	logic [2:0]  max_q;

	logic [2:0]  status_q;
	logic        transmit_q;
	logic [7:0]  oseq_q;
	logic [15:0] ohandle_q;
	logic [3:0]  oatt_q;
	logic        lost_q;

	logic                         empty, full, hit;
	logic [artq_pkg::IDX_W-1:0]   tail_nxt;
	logic [7:0]                   head_seq, head_cmd;
	logic [15:0]                  head_handle;
	logic [artq_pkg::TIMER_W-1:0] long_timer;
	logic [artq_pkg::ATT_W-1:0]   att_inc;

	logic                         push_we, head_adv;
	logic [artq_pkg::TIMER_W-1:0] timer_d;
	logic [artq_pkg::ATT_W-1:0]   att_d;
	logic [2:0]                   sts_d;
	logic                         tx_d, lost_d;
	logic [7:0]                   oseq_d;
	logic [15:0]                  ohandle_d;
	logic [3:0]                   oatt_d;

	assign tail_nxt    = artq_pkg::ring_next(tail_q);
	assign empty       = (head_q == tail_q);
	assign full        = (tail_nxt == head_q);
	assign head_seq    = slot_seq_q[head_q];
	assign head_cmd    = slot_cmd_q[head_q];
	assign head_handle = slot_handle_q[head_q];
	assign long_timer  = artq_pkg::TIMER_W'(base_q) * artq_pkg::TIMER_W'(factor_q);
	assign att_inc     = attempts_q + 1'b1;

	// stale slots count too: the search covers the whole store
	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < artq_pkg::DEPTH; i++) begin
			hit = hit | (slot_seq_q[i] == seq_q);
		end
	end

	always_comb begin
		push_we   = 1'b0;
		head_adv  = 1'b0;
		timer_d   = timer_q;
		att_d     = attempts_q;
		sts_d     = artq_pkg::STS_OK;
		tx_d      = 1'b0;
		lost_d    = 1'b0;
		oseq_d    = '0;
		ohandle_d = '0;
		oatt_d    = '0;
		unique case (cmd_q)
			artq_pkg::CMD_PUSH: begin
				if (full) begin
					sts_d  = artq_pkg::STS_FULL;
					lost_d = 1'b1;
				end else begin
					push_we = 1'b1;
				end
			end
			artq_pkg::CMD_ACK: begin
				if (!empty && head_seq == seq_q) begin
					head_adv = 1'b1;
					att_d    = '0;
					timer_d  = '0;
				end else begin
					sts_d = hit ? artq_pkg::STS_ACK_DUP : artq_pkg::STS_ACK_UNK;
				end
			end
			artq_pkg::CMD_POLL: begin
				if (empty) begin
					sts_d = artq_pkg::STS_EMPTY;
				end else begin
					oseq_d    = head_seq;
					ohandle_d = head_handle;
					if (attempts_q == '0) begin
						// first send: pairing commands get the long timeout
						timer_d = (head_cmd == pair_q) ? long_timer
							: artq_pkg::TIMER_W'(base_q);
						att_d   = artq_pkg::ATT_W'(1);
						tx_d    = 1'b1;
						oatt_d  = artq_pkg::ATT_W'(1);
					end else if (timer_q == '0) begin
						oatt_d = att_inc;
						if (att_inc > artq_pkg::ATT_W'(max_q)) begin
							head_adv = 1'b1;
							att_d    = '0;
							timer_d  = '0;
							sts_d    = artq_pkg::STS_EXHAUSTED;
							lost_d   = 1'b1;
						end else begin
							att_d   = att_inc;
							timer_d = artq_pkg::TIMER_W'(base_q);
							tx_d    = 1'b1;
						end
					end else begin
						sts_d  = artq_pkg::STS_WAITING;
						oatt_d = attempts_q;
					end
				end
			end
			artq_pkg::CMD_TICK: begin
				if (timer_q != '0) begin
					timer_d = timer_q - 1'b1;
				end
				sts_d = artq_pkg::STS_TICK;
			end
		endcase
	end

	// item capture and result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd;
			seq_q    <= seq;
			cbyte_q  <= command_byte;
			handle_q <= packet_handle;
		end
		if (ctl.exec) begin
			status_q   <= sts_d;
			transmit_q <= tx_d;
			oseq_q     <= oseq_d;
			ohandle_q  <= ohandle_d;
			oatt_q     <= oatt_d;
			lost_q     <= lost_d;
		end
	end

	// command and handle slots are only read between head and tail, so no reset
	always_ff @(posedge clk) begin
		if (ctl.exec && push_we) begin
			slot_cmd_q[tail_q]    <= cbyte_q;
			slot_handle_q[tail_q] <= handle_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < artq_pkg::DEPTH; i++) begin
				slot_seq_q[i] <= '0;
			end
			head_q     <= '0;
			tail_q     <= '0;
			attempts_q <= '0;
			timer_q    <= '0;
		end else if (ctl.exec) begin
			if (push_we) begin
				slot_seq_q[tail_q] <= seq_q;
				tail_q             <= tail_nxt;
			end
			if (head_adv) begin
				head_q <= artq_pkg::ring_next(head_q);
			end
			attempts_q <= att_d;
			timer_q    <= timer_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= artq_pkg::RST_BASE_TIMEOUT;
			factor_q <= artq_pkg::RST_LONG_FACTOR;
			pair_q   <= artq_pkg::RST_PAIRING_CODE;
			max_q    <= artq_pkg::RST_MAX_ATTEMPTS;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				artq_pkg::REG_BASE_TIMEOUT: base_q   <= cfg_data;
				artq_pkg::REG_LONG_FACTOR:  factor_q <= cfg_data[3:0];
				artq_pkg::REG_PAIRING_CODE: pair_q   <= cfg_data[7:0];
				artq_pkg::REG_MAX_ATTEMPTS: max_q    <= cfg_data[2:0];
			endcase
		end
	end

	assign status        = status_q;
	assign transmit      = transmit_q;
	assign out_seq       = oseq_q;
	assign out_handle    = ohandle_q;
	assign attempt_count = oatt_q;
	assign link_lost     = lost_q;

endmodule

// ===== hw/rtl/artq_ctrl.sv =====
// Controller: accept/execute state machine and result valid flag.
// Depends on artq_pkg; drives artq_datapath through artq_pkg::ctl_t.
module artq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output artq_pkg::ctl_t ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || rsp_ready;
	assign ctl.load  = req_valid && req_ready;
	assign ctl.exec  = (state_q == ST_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// hold until the result register can take the new result
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
			if (ctl.exec) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/ack_retry_transmit_queue_core.sv =====
// Stop-and-wait transmit ring with ack matching, retry timer and attempt limit.
// Capture, then execute: an item is captured on its transfer and executed into the
// result register once that register is free; no new item is taken until then, and a
// stalled result holds execution of the next item until the result register frees.
// Reset (arst_n, async): clears sequence slots, ring indexes, attempts and timer,
// and loads the register defaults; the block is ready for items once reset is released.
module ack_retry_transmit_queue_core (
	input logic        clk,
	input logic        arst_n,
	artq_req_if.sink   req,
	artq_rsp_if.source rsp,
	artq_cfg_if.sink   cfg
);

	artq_pkg::ctl_t ctl;

	assign cfg.ready = 1'b1;

	artq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	artq_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (req.cmd),
		.seq           (req.seq),
		.command_byte  (req.command_byte),
		.packet_handle (req.packet_handle),
		.cfg_we        (cfg.valid && cfg.ready),
		.cfg_idx       (cfg.idx),
		.cfg_data      (cfg.data),
		.status        (rsp.status),
		.transmit      (rsp.transmit),
		.out_seq       (rsp.out_seq),
		.out_handle    (rsp.out_handle),
		.attempt_count (rsp.attempt_count),
		.link_lost     (rsp.link_lost)
	);

	a_no_accept_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input taken in the cycle after a transfer");

	a_exec_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> rsp.valid)
		else $error("executed item left no result");

	a_transmit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.transmit |-> rsp.status == artq_pkg::STS_OK
			&& rsp.attempt_count != 4'd0)
		else $error("transmit without ok status or attempt");

	a_lost_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.link_lost |-> rsp.status == artq_pkg::STS_FULL
			|| rsp.status == artq_pkg::STS_EXHAUSTED)
		else $error("link loss without drop");

endmodule
